// ----- design/cdaf_pkg.sv -----
// shared types, constants and the fader multiplier function for the cd audio fader
package cdaf_pkg;

  localparam int LEVEL_W = 11;
  localparam int VOL_W   = 7;
  localparam int SMP_W   = 16;
  localparam int PROD_W  = 28;   // sample times multiplier, signed
  localparam int FADE_W  = 18;   // faded sample, signed
  localparam int MIX_W   = 25;   // faded times volume, signed
  localparam int MAG_W   = 24;   // magnitude of the mixed value
  localparam int QUO_W   = 17;   // magnitude after the percent division

  localparam logic [LEVEL_W-1:0] MUL_HIGH   = 11'h7fc;
  localparam logic [LEVEL_W-1:0] MUL_LOW    = 11'h003;
  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 11'h400;
  localparam logic [VOL_W-1:0]   FULL_VOL   = 7'd100;

  // ceil(2^30 / 100); exact floor division for magnitudes below 2^23
  localparam int                 RECIP_SH = 30;
  localparam logic [MAG_W-1:0]   RECIP    = 24'd10737419;

  localparam logic [SMP_W-1:0] SAT_MAX = 16'h7fff;
  localparam logic [SMP_W-1:0] SAT_MIN = 16'h8000;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MIX,
    ST_QUO,
    ST_MRG
  } state_t;

  // step enables shared by both lanes
  typedef struct packed {
    logic ld;
    logic mix;
    logic quo;
  } lane_ctl_t;

  function automatic logic [LEVEL_W-1:0] fader_mul(input logic [LEVEL_W-1:0] lvl);
    logic [LEVEL_W-1:0] hi;
    hi = lvl & MUL_HIGH;
    fader_mul = (hi != '0) ? hi : (lvl & MUL_LOW);
  endfunction

endpackage

// ----- design/cd_audio_fader_ramp.sv -----
// top level of the cd audio fader: config registers, level ramp, sequencer, lanes, merge
//
//  channel | direction | transfer
//  in_     | slave     | tdata = sample_left, sample_right; tuser = playing
//  out_    | master    | tdata = out_left, out_right
//  cfg_    | apb       | 0x0 fade_target, 0x4 mix_volume_percent
//
//  each stereo pair goes through the accept with the fader multiply, the volume multiply,
//  the reciprocal multiply for the divide by 100, then the merge into the output register
//  the level steps toward fade_target at the accepting edge of each playing pair
//  a new pair is taken once the previous one sits in the output register
//  reset restores level 1024, target 1024 and volume 100
module cd_audio_fader_ramp
  import cdaf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [2*SMP_W-1:0]  in_tdata,   // [15:0] sample_left, [31:16] sample_right
  input  logic                in_tuser,   // [0] playing
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [2*SMP_W-1:0]  out_tdata,  // [15:0] out_left, [31:16] out_right
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);

  localparam logic REG_FADE = 1'b0;
  localparam logic REG_VOL  = 1'b1;

  logic [LEVEL_W-1:0] target_r;
  logic [VOL_W-1:0]   vol_r;
  logic [LEVEL_W-1:0] level_r, level_nxt;
  logic               play_r;
  state_t             state_r, state_nxt;
  lane_ctl_t          ctl;
  logic               accept;
  logic               cfg_wr;
  logic               out_free;
  logic               mrg_load;
  logic [LEVEL_W-1:0] mul;
  logic [QUO_W-1:0]   quo_l, quo_rt;
  logic               neg_l, neg_rt;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    unique case (cfg_paddr[2])
      REG_FADE: cfg_prdata = {{(32-LEVEL_W){1'b0}}, target_r};
      REG_VOL:  cfg_prdata = {{(32-VOL_W){1'b0}}, vol_r};
      default:  cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= FULL_LEVEL;
      vol_r    <= FULL_VOL;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == REG_FADE) begin
        target_r <= cfg_pwdata[LEVEL_W-1:0];
      end else begin
        vol_r <= cfg_pwdata[VOL_W-1:0];
      end
    end
  end

  assign accept = in_tvalid && in_tready;
  assign mul    = fader_mul(level_r);

  always_comb begin
    level_nxt = level_r;
    if (accept && in_tuser) begin
      if (level_r < target_r) begin
        level_nxt = level_r + 1'b1;
      end else if (level_r > target_r) begin
        level_nxt = level_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= FULL_LEVEL;
      state_r <= ST_IDLE;
    end else begin
      level_r <= level_nxt;
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      play_r <= in_tuser;
    end
  end

  assign out_free = !out_tvalid || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_tvalid) state_nxt = ST_MIX;
      ST_MIX:  state_nxt = ST_QUO;
      ST_QUO:  state_nxt = ST_MRG;
      ST_MRG:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready = 1'b0;
    ctl       = '0;
    mrg_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        ctl.ld    = in_tvalid;
      end
      ST_MIX:  ctl.mix = 1'b1;
      ST_QUO:  ctl.quo = 1'b1;
      ST_MRG:  mrg_load = out_free;
      default: ;
    endcase
  end

  cdaf_lane u_lane_l (
    .clk    (clk),
    .ctl    (ctl),
    .sample (signed'(in_tdata[SMP_W-1:0])),
    .mul    (mul),
    .vol    (vol_r),
    .quo    (quo_l),
    .neg    (neg_l)
  );

  cdaf_lane u_lane_r (
    .clk    (clk),
    .ctl    (ctl),
    .sample (signed'(in_tdata[2*SMP_W-1:SMP_W])),
    .mul    (mul),
    .vol    (vol_r),
    .quo    (quo_rt),
    .neg    (neg_rt)
  );

  cdaf_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (mrg_load),
    .playing    (play_r),
    .quo_l      (quo_l),
    .neg_l      (neg_l),
    .quo_r      (quo_rt),
    .neg_r      (neg_rt),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ----- design/cdaf_lane.sv -----
// one channel lane: fader multiply, volume multiply, divide by 100 via reciprocal
module cdaf_lane
  import cdaf_pkg::*;
(
  input  logic                      clk,
  input  lane_ctl_t                 ctl,
  input  logic signed [SMP_W-1:0]   sample,
  input  logic [LEVEL_W-1:0]        mul,
  input  logic [VOL_W-1:0]          vol,
  output logic [QUO_W-1:0]          quo,
  output logic                      neg
);

  logic signed [PROD_W-1:0] prod_r;
  logic [VOL_W-1:0]         vol_r;
  logic signed [PROD_W-1:0] bias;
  logic signed [PROD_W-1:0] biased;
  logic signed [FADE_W-1:0] faded;
  logic signed [MIX_W-1:0]  mix_r;
  logic signed [MIX_W-1:0]  mix_abs;
  logic [MAG_W-1:0]         mag;
  logic [2*MAG_W-1:0]       recip_prod;
  logic [QUO_W-1:0]         quo_r;
  logic                     neg_r;

  // round toward zero on the shift by adding 1023 to negative products
  assign bias    = signed'({{(PROD_W-10){1'b0}}, {10{prod_r[PROD_W-1]}}});
  assign biased  = prod_r + bias;
  assign faded   = biased[PROD_W-1:10];
  assign mix_abs = mix_r[MIX_W-1] ? -mix_r : mix_r;
  assign mag     = mix_abs[MAG_W-1:0];
  assign recip_prod = mag * RECIP;

  always_ff @(posedge clk) begin
    if (ctl.ld) begin
      prod_r <= sample * signed'({1'b0, mul});
      vol_r  <= vol;
    end
    if (ctl.mix) begin
      mix_r <= MIX_W'(faded * signed'({1'b0, vol_r}));
    end
    if (ctl.quo) begin
      quo_r <= recip_prod[RECIP_SH +: QUO_W];
      neg_r <= mix_r[MIX_W-1];
    end
  end

  assign quo = quo_r;
  assign neg = neg_r;

endmodule

// ----- design/cdaf_merge.sv -----
// merge stage: sign, saturation, silence and the output register for the stereo pair
module cdaf_merge
  import cdaf_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  logic                playing,
  input  logic [QUO_W-1:0]    quo_l,
  input  logic                neg_l,
  input  logic [QUO_W-1:0]    quo_r,
  input  logic                neg_r,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [2*SMP_W-1:0]  out_tdata
);

  function automatic logic [SMP_W-1:0] finish(input logic [QUO_W-1:0] q, input logic n,
                                              input logic play);
    logic signed [QUO_W:0] v;
    v = n ? -signed'({1'b0, q}) : signed'({1'b0, q});
    if (!play) begin
      finish = '0;
    end else if (v > signed'({{(QUO_W+1-SMP_W){1'b0}}, SAT_MAX})) begin
      finish = SAT_MAX;
    end else if (v < signed'({{(QUO_W+1-SMP_W){1'b1}}, SAT_MIN})) begin
      finish = SAT_MIN;
    end else begin
      finish = v[SMP_W-1:0];
    end
  endfunction

  logic                valid_r, valid_nxt;
  logic [2*SMP_W-1:0]  data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= {finish(quo_r, neg_r, playing), finish(quo_l, neg_l, playing)};
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

// ----- bench/tb.sv -----
// testbench for the cd audio fader: predicts every faded stereo pair and checks the output stream
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cdaf_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 8;
  localparam int MAX_PRINTED    = 40;

  localparam logic [2:0] ADDR_FADE_TARGET = 3'h0;
  localparam logic [2:0] ADDR_MIX_VOLUME  = 3'h4;

  // packed so that left sits in the low half, as on the bus
  typedef struct packed {
    logic [SMP_W-1:0] right;
    logic [SMP_W-1:0] left;
  } stereo_t;

  logic               clk         = 1'b0;
  logic               rst_n       = 1'b0;
  logic               in_tvalid   = 1'b0;
  logic               in_tready;
  logic [2*SMP_W-1:0] in_tdata    = '0;
  logic               in_tuser    = 1'b0;
  logic               out_tvalid;
  logic               out_tready  = 1'b0;
  logic [2*SMP_W-1:0] out_tdata;
  logic               cfg_psel    = 1'b0;
  logic               cfg_penable = 1'b0;
  logic               cfg_pwrite  = 1'b0;
  logic [2:0]         cfg_paddr   = '0;
  logic [31:0]        cfg_pwdata  = '0;
  logic [31:0]        cfg_prdata;
  logic               cfg_pready;

  // predictor state, mirrors the block after reset
  logic [LEVEL_W-1:0] fade_level = FULL_LEVEL;
  logic [LEVEL_W-1:0] fade_goal  = FULL_LEVEL;
  logic [VOL_W-1:0]   mix_vol    = FULL_VOL;

  stereo_t faded_q[$];
  int      mismatches  = 0;
  bit      steady      = 1'b0;
  int      stall_left  = 0;
  int      idle_cycles = 0;

  cd_audio_fader_ramp dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SMP_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  // one channel: fader multiply, divide by 1024, volume, divide by 100, then clamp
  function automatic logic [SMP_W-1:0] scale_sample(logic signed [SMP_W-1:0] s,
                                                    logic [LEVEL_W-1:0] mul,
                                                    logic [VOL_W-1:0] vol);
    int faded;
    int mixed;
    faded = (int'(s) * int'(mul)) / 1024;
    mixed = (faded * int'(vol)) / 100;
    if (mixed > 32767) mixed = 32767;
    else if (mixed < -32768) mixed = -32768;
    return mixed[SMP_W-1:0];
  endfunction

  // output uses the level before the step; level moves only while playing
  function automatic stereo_t predict_fade(logic [SMP_W-1:0] l, logic [SMP_W-1:0] r,
                                           logic play);
    stereo_t res;
    logic [LEVEL_W-1:0] mul;
    res = '0;
    if (play) begin
      mul = ((fade_level & MUL_HIGH) != '0) ? (fade_level & MUL_HIGH)
                                            : (fade_level & MUL_LOW);
      res.left  = scale_sample(l, mul, mix_vol);
      res.right = scale_sample(r, mul, mix_vol);
      if (fade_level < fade_goal) fade_level++;
      else if (fade_level > fade_goal) fade_level--;
    end
    return res;
  endfunction

  // valid stays high after a transfer so back-to-back pairs need no second assignment
  task automatic send_pair(logic [SMP_W-1:0] l, logic [SMP_W-1:0] r, logic play);
    int gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {r, l};
    in_tuser  <= play;
    do @(posedge clk); while (!in_tready);
    faded_q.push_back(predict_fade(l, r, play));
  endtask

  task automatic send_random(int play_pct);
    send_pair(rand_sample(), rand_sample(), $urandom_range(0, 99) < play_pct);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (faded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= addr;
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  task automatic apb_read_check(logic [2:0] addr, logic [31:0] want);
    logic [31:0] got;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= addr;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(negedge clk);
      got = cfg_prdata;
      @(posedge clk);
    end while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== want)
      report_mismatch($sformatf("register %h read %h, want %h", addr, got, want));
  endtask

  // upper bits of the write data carry noise that the register must drop
  task automatic set_register(logic [2:0] addr, int value);
    int width;
    drain();
    width = (addr == ADDR_FADE_TARGET) ? LEVEL_W : VOL_W;
    apb_write(addr, (32'($urandom) << width) | 32'(value));
    if (addr == ADDR_FADE_TARGET) fade_goal = value[LEVEL_W-1:0];
    else mix_vol = value[VOL_W-1:0];
    apb_read_check(addr, 32'(value));
  endtask

  task automatic test_reset_state();
    apb_read_check(ADDR_FADE_TARGET, 32'(FULL_LEVEL));
    apb_read_check(ADDR_MIX_VOLUME, 32'(FULL_VOL));
    steady = 1'b1;
    send_pair(16'h7fff, 16'h8000, 1'b1);
    send_pair(16'h8000, 16'h7fff, 1'b1);
    send_pair(16'h0000, 16'h0000, 1'b1);
    send_pair(16'hffff, 16'h0001, 1'b1);
    send_pair(16'h4000, 16'hc000, 1'b1);
    // not playing: silent output whatever the samples
    send_pair(16'h5a5a, 16'ha5a5, 1'b0);
    send_pair(16'h7fff, 16'h8000, 1'b0);
    steady = 1'b0;
  endtask

  task automatic test_volume_extremes();
    set_register(ADDR_MIX_VOLUME, 127);
    send_pair(16'h7fff, 16'h8000, 1'b1);
    send_pair(16'h1234, 16'hedcc, 1'b1);
    send_pair(16'hffff, 16'h0001, 1'b1);
    set_register(ADDR_MIX_VOLUME, 0);
    send_pair(16'h7fff, 16'h8000, 1'b1);
    send_pair(16'h8000, 16'h7fff, 1'b1);
    set_register(ADDR_MIX_VOLUME, 1);
    send_pair(16'h7fff, 16'h8000, 1'b1);
    send_pair(16'h0063, 16'hff9d, 1'b1);
    set_register(ADDR_MIX_VOLUME, 100);
  endtask

  // level climbs past 1024, so large samples can saturate
  task automatic test_ramp_above_full();
    set_register(ADDR_MIX_VOLUME, $urandom_range(90, 110));
    set_register(ADDR_FADE_TARGET, 1060);
    repeat (80) send_random(92);
  endtask

  // walks the level all the way down through the small multipliers to mute
  task automatic test_ramp_to_mute();
    set_register(ADDR_MIX_VOLUME, $urandom_range(60, 127));
    set_register(ADDR_FADE_TARGET, 0);
    while (fade_level != '0) send_random(90);
    repeat (40) send_random(85);
  endtask

  task automatic test_ramp_up_from_mute();
    set_register(ADDR_MIX_VOLUME, 100);
    set_register(ADDR_FADE_TARGET, 2047);
    repeat (80) send_random(90);
  endtask

  task automatic test_random_settings();
    int goal;
    repeat (5) begin
      case ($urandom_range(0, 4))
        0: goal = int'(fade_level) + $urandom_range(0, 60) - 30;
        1: goal = 0;
        2: goal = 2047;
        3: goal = int'(FULL_LEVEL);
        default: goal = $urandom_range(0, 2047);
      endcase
      if (goal < 0) goal = 0;
      if (goal > 2047) goal = 2047;
      set_register(ADDR_FADE_TARGET, goal);
      case ($urandom_range(0, 4))
        0: set_register(ADDR_MIX_VOLUME, 0);
        1: set_register(ADDR_MIX_VOLUME, 127);
        2: set_register(ADDR_MIX_VOLUME, 100);
        default: set_register(ADDR_MIX_VOLUME, $urandom_range(0, 127));
      endcase
      steady = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(25, 45)) send_random(80);
    end
    steady = 1'b0;
  endtask

  // result side back-pressure: random stalls, none during steady stretches
  always @(posedge clk) begin
    if (steady) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= pick_gap();
    end
  end

  always @(posedge clk) begin
    stereo_t want;
    stereo_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (faded_q.size() == 0) begin
        report_mismatch($sformatf("pair %h with nothing expected", out_tdata));
      end else begin
        want = faded_q.pop_front();
        if (got.left !== want.left)
          report_mismatch($sformatf("out_left %h, want %h", got.left, want.left));
        if (got.right !== want.right)
          report_mismatch($sformatf("out_right %h, want %h", got.right, want.right));
      end
    end
  end

  // counts cycles with no transfer on any port
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_psel && cfg_penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_volume_extremes();
    test_ramp_above_full();
    test_ramp_to_mute();
    test_ramp_up_from_mute();
    test_random_settings();
    drain();
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
